### sv/multichannel_servo_ramp_defines.svh
// ----------------------------------------------------------------------------
// Servo ramp assertion macros
// Checks compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SERVO_RAMP_DEFINES_SVH
`define MULTICHANNEL_SERVO_RAMP_DEFINES_SVH
`ifndef SYNTHESIS
`define MSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MSR_ASSERT(lbl, prop, msg)
`define MSR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### sv/msr_pkg.sv
// ----------------------------------------------------------------------------
// Servo ramp package
// Fixed widths and constants of the servo ramp generator.
// ----------------------------------------------------------------------------
package msr_pkg;
  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned TIME_W     = 26;
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned DVD_W      = 42;
  localparam int unsigned DIV_STEPS  = 42;
  localparam int unsigned CNT_W      = 6;
  localparam logic [7:0]  STEP_RST   = 8'd20;
  localparam logic [15:0] START_RST  = 16'd1500;
  localparam logic        CFG_STEP   = 1'b0;
  localparam logic        CFG_START  = 1'b1;
  localparam logic        MODE_CMD   = 1'b0;
  localparam logic        KIND_WIDTH = 1'b0;
  localparam logic        KIND_STAT  = 1'b1;
  localparam logic [1:0]  QS_MOVING  = 2'd1;
  localparam logic [1:0]  QS_DONE    = 2'd2;

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [WIDTH_W-1:0] width_t;
endpackage

### sv/multichannel_servo_ramp.sv
// ----------------------------------------------------------------------------
// Multichannel servo ramp
// Batched servo targets, linear pulse-width ramps advanced by tick items.
// ----------------------------------------------------------------------------
//  channel  ports                          handshake
//  input    in_*                           start high, busy low
//  result   out_*                          out_valid strobe, one cycle
//  config   cfg_we, cfg_index, cfg_data    cfg_we high
//
// Valid commands with nonzero speed pass S_CMUL, the bit-serial 42-step
// divider and S_CFIN, others only S_CFIN. A tick scans every channel, runs
// the same divider for each channel still mid-ramp, and ends in S_TSTAT.
// Reset is synchronous and needs no clearing pass. Results cannot be stalled.
`include "multichannel_servo_ramp_defines.svh"
module multichannel_servo_ramp
  import msr_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [3:0]  in_channel,
  input  logic [15:0] in_target_width,
  input  logic [15:0] in_speed,
  input  logic [15:0] in_move_time,
  input  logic        in_last_in_batch,
  output logic        out_valid,
  output logic        out_kind,
  output logic [3:0]  out_channel,
  output logic [15:0] out_width,
  output logic [1:0]  out_query_status,
  output logic        out_done_event,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMUL  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CFIN  = 3'd3;
  localparam logic [2:0] S_TSCAN = 3'd4;
  localparam logic [2:0] S_TMUL  = 3'd5;
  localparam logic [2:0] S_TEMIT = 3'd6;
  localparam logic [2:0] S_TSTAT = 3'd7;

  logic [2:0]       state_r;
  logic [7:0]       tick_step_r;
  width_t           start_pos_r;
  logic             mode_r, lastb_r, cvalid_r;
  logic [3:0]       ch_r;
  width_t           tw_r, speed_r, mt_r, dist_r, mag_r;
  logic [IW-1:0]    idx_r;
  logic [DVD_W-1:0] dvd_r;
  time_t            rem_r, dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             updated_r, done_rep_r;
  logic [1:0]       status_r;
  time_t            batch_r;

  width_t cw_r [CHANNELS];
  width_t rs_r [CHANNELS];
  width_t rt_r [CHANNELS];
  time_t  total_r [CHANNELS];
  time_t  left_r [CHANNELS];
  width_t stg_r [CHANNELS];
  logic [CHANNELS-1:0] stv_r, driven_r;

  logic             out_valid_r, out_kind_r, out_ev_r, out_last_r;
  logic [3:0]       out_ch_r;
  width_t           out_w_r;
  logic [1:0]       out_qs_r;

  logic [TIME_W:0]  rem_sh;
  logic             qbit;
  time_t            rem_nxt;
  logic [7:0]       stp;
  logic             idx_last;
  width_t           cw_in, cw_idx, w_interp, q16;
  time_t            t_cmd, batch_nxt, tmax;
  logic             in_ok;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign qbit    = (rem_sh >= {1'b0, dsr_r});
  assign rem_nxt = qbit ? TIME_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[TIME_W-1:0];

  assign stp      = (tick_step_r == 8'd0) ? 8'd1 : tick_step_r;
  assign idx_last = (idx_r == IW'(CHANNELS - 1));
  assign cw_in    = driven_r[in_channel[IW-1:0]] ? cw_r[in_channel[IW-1:0]] : start_pos_r;
  assign cw_idx   = driven_r[idx_r] ? cw_r[idx_r] : start_pos_r;
  assign in_ok    = ({1'b0, in_channel} < 5'(CHANNELS)) && (in_target_width != '0);
  assign q16      = dvd_r[WIDTH_W-1:0];
  assign w_interp = (rs_r[idx_r] > rt_r[idx_r]) ? width_t'(rt_r[idx_r] + q16)
                                                : width_t'(rt_r[idx_r] - q16);

  always_comb begin
    if (speed_r != '0 && dvd_r[TIME_W-1:0] > TIME_W'(mt_r)) begin
      t_cmd = dvd_r[TIME_W-1:0];
    end else begin
      t_cmd = TIME_W'(mt_r);
    end
    batch_nxt = (cvalid_r && t_cmd > batch_r) ? t_cmd : batch_r;
    tmax      = (batch_nxt < TIME_W'(stp)) ? TIME_W'(stp) : batch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_step_r <= STEP_RST;
      start_pos_r <= START_RST;
      stv_r       <= '0;
      driven_r    <= '0;
      batch_r     <= '0;
      done_rep_r  <= 1'b0;
      status_r    <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        left_r[c] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEP:  tick_step_r <= cfg_data[7:0];
          CFG_START: start_pos_r <= cfg_data;
          default:   ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r    <= in_mode;
            ch_r      <= in_channel;
            tw_r      <= in_target_width;
            speed_r   <= in_speed;
            mt_r      <= in_move_time;
            lastb_r   <= in_last_in_batch;
            cvalid_r  <= in_ok;
            dist_r    <= (in_target_width > cw_in) ? width_t'(in_target_width - cw_in)
                                                   : width_t'(cw_in - in_target_width);
            idx_r     <= '0;
            updated_r <= 1'b0;
            if (in_mode != MODE_CMD) begin
              state_r <= S_TSCAN;
            end else if (in_ok && in_speed != '0) begin
              state_r <= S_CMUL;
            end else begin
              state_r <= S_CFIN;
            end
          end
        end
        S_CMUL: begin
          dvd_r   <= DVD_W'(dist_r * 10'(MS_PER_S));
          dsr_r   <= TIME_W'(speed_r);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[DVD_W-2:0], qbit};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= (mode_r == MODE_CMD) ? S_CFIN : S_TEMIT;
          end
        end
        S_CFIN: begin
          if (cvalid_r) begin
            stg_r[ch_r[IW-1:0]] <= tw_r;
            stv_r[ch_r[IW-1:0]] <= 1'b1;
          end
          if (lastb_r) begin
            batch_r <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
              if (stv_r[c] || (cvalid_r && ch_r[IW-1:0] == IW'(c))) begin
                rs_r[c]    <= driven_r[c] ? cw_r[c] : start_pos_r;
                rt_r[c]    <= (cvalid_r && ch_r[IW-1:0] == IW'(c)) ? tw_r : stg_r[c];
                total_r[c] <= tmax;
                left_r[c]  <= tmax;
                stv_r[c]   <= 1'b0;
              end
            end
          end else begin
            batch_r <= batch_nxt;
          end
          state_r <= S_IDLE;
        end
        S_TSCAN: begin
          if (left_r[idx_r] != '0) begin
            updated_r       <= 1'b1;
            done_rep_r      <= 1'b0;
            status_r        <= QS_MOVING;
            driven_r[idx_r] <= 1'b1;
            if (left_r[idx_r] <= TIME_W'(stp)) begin
              left_r[idx_r] <= '0;
              cw_r[idx_r]   <= rt_r[idx_r];
              out_valid_r   <= 1'b1;
              out_kind_r    <= KIND_WIDTH;
              out_ch_r      <= 4'(idx_r);
              out_w_r       <= rt_r[idx_r];
              out_qs_r      <= '0;
              out_ev_r      <= 1'b0;
              out_last_r    <= 1'b0;
              if (idx_last) begin
                state_r <= S_TSTAT;
              end else begin
                idx_r <= idx_r + 1'b1;
              end
            end else begin
              left_r[idx_r] <= left_r[idx_r] - TIME_W'(stp);
              mag_r <= (rs_r[idx_r] > rt_r[idx_r]) ? width_t'(rs_r[idx_r] - rt_r[idx_r])
                                                   : width_t'(rt_r[idx_r] - rs_r[idx_r]);
              state_r <= S_TMUL;
            end
          end else if (idx_last) begin
            state_r <= S_TSTAT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TMUL: begin
          dvd_r   <= DVD_W'(mag_r * left_r[idx_r]);
          dsr_r   <= total_r[idx_r];
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_TEMIT: begin
          cw_r[idx_r] <= w_interp;
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_WIDTH;
          out_ch_r    <= 4'(idx_r);
          out_w_r     <= w_interp;
          out_qs_r    <= '0;
          out_ev_r    <= 1'b0;
          out_last_r  <= 1'b0;
          if (idx_last) begin
            state_r <= S_TSTAT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_TSCAN;
          end
        end
        S_TSTAT: begin
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_STAT;
          out_ch_r    <= '0;
          out_w_r     <= '0;
          out_last_r  <= 1'b1;
          if (!updated_r && !done_rep_r) begin
            done_rep_r <= 1'b1;
            status_r   <= QS_DONE;
            out_qs_r   <= QS_DONE;
            out_ev_r   <= 1'b1;
          end else begin
            out_qs_r   <= status_r;
            out_ev_r   <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_channel      = out_ch_r;
  assign out_width        = out_w_r;
  assign out_query_status = out_qs_r;
  assign out_done_event   = out_ev_r;
  assign out_last         = out_last_r;

  `MSR_ASSERT(a_stat_last, out_valid |-> (out_kind == out_last), "status item must close tick")
  `MSR_ASSERT(a_qs_range, out_valid |-> (out_query_status != 2'd3), "bad query status")
  `MSR_ASSERT(a_ev_done, out_valid && out_done_event |-> (out_query_status == QS_DONE), "stray event")
  `MSR_ASSERT_NEXT(a_tick_busy, start && !busy && in_mode, busy, "tick item not taken")
endmodule
